### sv/pdid_pkg.sv
package pdid_pkg;

  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 32;
  localparam int COPY_LEN_W = 17;

  // Copy length that a zero length field stands for
  localparam logic [COPY_LEN_W-1:0] COPY_MAX = 17'h10000;

  typedef enum logic [1:0] {
    KIND_LITERAL,
    KIND_COPY,
    KIND_OK,
    KIND_ERROR
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BASE_SIZE,
    ERR_NO_CMDS,
    ERR_ZERO_CMD,
    ERR_COPY_RANGE,
    ERR_TRUNCATED,
    ERR_FINAL_SIZE
  } err_t;

  typedef struct packed {
    kind_t                  kind;
    logic [BYTE_W-1:0]      literal;
    logic [SIZE_W-1:0]      copy_offset;
    logic [COPY_LEN_W-1:0]  copy_length;
    err_t                   error_code;
    logic                   is_last;
  } result_t;

  function automatic result_t mk_status(input kind_t kind, input err_t code);
    result_t r;
    r             = '0;
    r.kind        = kind;
    r.error_code  = code;
    r.is_last     = 1'b1;
    return r;
  endfunction

endpackage

### sv/pdid_in_if.sv
interface pdid_in_if;
  logic                        valid;
  logic                        ready;
  logic [pdid_pkg::BYTE_W-1:0] delta_byte;
  logic                        end_of_delta;

  modport source(output valid, output delta_byte, output end_of_delta, input ready);
  modport sink(input valid, input delta_byte, input end_of_delta, output ready);
endinterface

### sv/pdid_out_if.sv
interface pdid_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [pdid_pkg::BYTE_W-1:0]     literal;
  logic [pdid_pkg::SIZE_W-1:0]     copy_offset;
  logic [pdid_pkg::COPY_LEN_W-1:0] copy_length;
  logic [2:0]                      error_code;
  logic                            is_last;

  modport source(output valid, output kind, output literal, output copy_offset,
                 output copy_length, output error_code, output is_last, input ready);
  modport sink(input valid, input kind, input literal, input copy_offset,
               input copy_length, input error_code, input is_last, output ready);
endinterface

### sv/pack_delta_instruction_decoder.sv
// A delta byte transfer is held in the input register until the result queue has room;
// its results then enter the queue together (a copy or literal may precede the closing status).
// Throughput: 1 delta byte per cycle, while the 4-entry result queue holds at most
// 2 results; a stalled result sink or bursts of two results throttle intake there.
// Reset (rst, synchronous): decoder returns to the source length header, base_size
// clears to 0 and the result queue empties.
module pack_delta_instruction_decoder #(
  parameter int LEN_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [pdid_pkg::SIZE_W-1:0] cfg_wr_data,
  pdid_in_if.sink                     delta,
  pdid_out_if.source                  result
);

  localparam int BASE_CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;
  localparam int PROD_CMP_W = (LEN_BITS > 33) ? LEN_BITS : 33;
  localparam int PROD_W     = 33;
  localparam int CLEN_W     = 24;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [PROD_W-1:0] PROD_MAX = {PROD_W{1'b1}};

  typedef enum logic [2:0] {
    PH_SRC,
    PH_TGT,
    PH_CMD,
    PH_OPS,
    PH_LIT
  } phase_t;

  // Configuration
  logic [pdid_pkg::SIZE_W-1:0] base_size;

  // Input register
  logic                        stage_valid;
  logic [pdid_pkg::BYTE_W-1:0] stage_byte;
  logic                        stage_end;
  logic                        fire;

  // Decoder state
  phase_t                      phase,     phase_next;
  logic [LEN_BITS-1:0]         len_acc,   len_acc_next;
  logic [5:0]                  vshift,    vshift_next;
  logic [LEN_BITS-1:0]         target_len, target_len_next;
  logic [6:0]                  op_flags,  op_flags_next;
  logic [pdid_pkg::SIZE_W-1:0] off_acc,   off_acc_next;
  logic [CLEN_W-1:0]           clen_acc,  clen_acc_next;
  logic [6:0]                  lit_rem,   lit_rem_next;
  logic [PROD_W-1:0]           produced,  produced_next;
  logic                        err_latched, err_latched_next;

  // Decode datapath
  logic [LEN_BITS-1:0]         acc_new;
  logic [2:0]                  op_idx;
  logic [pdid_pkg::SIZE_W-1:0] off_ops;
  logic [CLEN_W-1:0]           clen_ops;
  logic [6:0]                  flags_ops;
  logic [pdid_pkg::SIZE_W-1:0] cp_off;
  logic [CLEN_W-1:0]           cp_clen;
  logic [CLEN_W-1:0]           cp_len;
  logic [pdid_pkg::SIZE_W:0]   cp_end;
  logic                        cp_bad;
  logic [CLEN_W-1:0]           prod_amount;
  logic [PROD_W:0]             prod_sum;
  logic [PROD_W-1:0]           prod_sat;

  pdid_pkg::result_t           main_res, end_res, res0, res1;
  logic                        main_has, end_has;
  logic [1:0]                  res_cnt;

  // Result queue
  pdid_pkg::result_t           q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]          q_wr, q_rd;
  logic [Q_CNT_W-1:0]          q_cnt;
  logic                        q_pop;

  // Hold the byte while the queue lacks room for two results
  assign fire        = stage_valid && (q_cnt <= Q_CNT_W'(Q_DEPTH - 2));
  assign delta.ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (delta.valid && delta.ready) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (delta.valid && delta.ready) begin
      stage_byte <= delta.delta_byte;
      stage_end  <= delta.end_of_delta;
    end
  end

  // Varint accumulate; bits at or above LEN_BITS fall off the shift
  assign acc_new = len_acc | (LEN_BITS'(stage_byte[6:0]) << vshift);

  // Lowest pending operand byte
  always_comb begin
    op_idx = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (op_flags[i]) begin
        op_idx = 3'(i);
      end
    end
  end

  always_comb begin
    off_ops  = off_acc;
    clen_ops = clen_acc;
    if (!op_idx[2]) begin
      off_ops = off_acc | (pdid_pkg::SIZE_W'(stage_byte) << {op_idx[1:0], 3'b000});
    end else begin
      clen_ops = clen_acc | (CLEN_W'(stage_byte) << {op_idx[1:0], 3'b000});
    end
  end

  assign flags_ops = op_flags & (op_flags - 7'd1);

  // Copy bounds check, shared by bare copies and copies with operands
  assign cp_off  = (phase == PH_OPS) ? off_ops : '0;
  assign cp_clen = (phase == PH_OPS) ? clen_ops : '0;
  assign cp_len  = (cp_clen == '0) ? CLEN_W'(pdid_pkg::COPY_MAX) : cp_clen;
  assign cp_end  = {1'b0, cp_off} + (pdid_pkg::SIZE_W + 1)'(cp_len);
  assign cp_bad  = (cp_len > CLEN_W'(pdid_pkg::COPY_MAX)) || (cp_end > {1'b0, base_size});

  // Saturating produced count
  assign prod_amount = (phase == PH_LIT) ? CLEN_W'(1) : cp_len;
  assign prod_sum    = {1'b0, produced} + (PROD_W + 1)'(prod_amount);
  assign prod_sat    = prod_sum[PROD_W] ? PROD_MAX : prod_sum[PROD_W-1:0];

  // Decode one byte
  always_comb begin
    logic done_early;

    phase_next       = phase;
    len_acc_next     = len_acc;
    vshift_next      = vshift;
    target_len_next  = target_len;
    op_flags_next    = op_flags;
    off_acc_next     = off_acc;
    clen_acc_next    = clen_acc;
    lit_rem_next     = lit_rem;
    produced_next    = produced;
    err_latched_next = err_latched;
    main_res         = '0;
    main_has         = 1'b0;
    end_res          = '0;
    end_has          = 1'b0;
    done_early       = 1'b0;

    if (err_latched) begin
      done_early = 1'b1;
      if (stage_end) begin
        err_latched_next = 1'b0;
        phase_next       = PH_SRC;
      end
    end else begin
      unique case (phase)
        PH_SRC, PH_TGT: begin
          len_acc_next = acc_new;
          vshift_next  = (vshift >= 6'd57) ? 6'd63 : vshift + 6'd7;
          if (!stage_byte[7]) begin
            if (phase == PH_SRC) begin
              if (BASE_CMP_W'(acc_new) != BASE_CMP_W'(base_size)) begin
                main_res         = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR,
                                                       pdid_pkg::ERR_BASE_SIZE);
                main_has         = 1'b1;
                err_latched_next = 1'b1;
              end else begin
                phase_next   = PH_TGT;
                len_acc_next = '0;
                vshift_next  = '0;
              end
            end else begin
              target_len_next = acc_new;
              phase_next      = PH_CMD;
              if (stage_end) begin
                main_res         = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR,
                                                       pdid_pkg::ERR_NO_CMDS);
                main_has         = 1'b1;
                err_latched_next = 1'b1;
                done_early       = 1'b1;
              end
            end
          end
        end
        PH_CMD: begin
          if (stage_byte[7]) begin
            op_flags_next = stage_byte[6:0];
            off_acc_next  = '0;
            clen_acc_next = '0;
            if (stage_byte[6:0] == 7'd0) begin
              main_has = 1'b1;
              if (cp_bad) begin
                main_res         = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR,
                                                       pdid_pkg::ERR_COPY_RANGE);
                err_latched_next = 1'b1;
              end else begin
                main_res.kind        = pdid_pkg::KIND_COPY;
                main_res.copy_offset = cp_off;
                main_res.copy_length = cp_len[pdid_pkg::COPY_LEN_W-1:0];
                produced_next        = prod_sat;
              end
            end else begin
              phase_next = PH_OPS;
            end
          end else if (stage_byte != '0) begin
            lit_rem_next = stage_byte[6:0];
            phase_next   = PH_LIT;
          end else begin
            main_res         = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR,
                                                   pdid_pkg::ERR_ZERO_CMD);
            main_has         = 1'b1;
            err_latched_next = 1'b1;
          end
        end
        PH_OPS: begin
          off_acc_next  = off_ops;
          clen_acc_next = clen_ops;
          op_flags_next = flags_ops;
          if (flags_ops == 7'd0) begin
            main_has = 1'b1;
            if (cp_bad) begin
              main_res         = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR,
                                                     pdid_pkg::ERR_COPY_RANGE);
              err_latched_next = 1'b1;
            end else begin
              main_res.kind        = pdid_pkg::KIND_COPY;
              main_res.copy_offset = cp_off;
              main_res.copy_length = cp_len[pdid_pkg::COPY_LEN_W-1:0];
              produced_next        = prod_sat;
              phase_next           = PH_CMD;
            end
          end
        end
        PH_LIT: begin
          main_res.kind    = pdid_pkg::KIND_LITERAL;
          main_res.literal = stage_byte;
          main_has         = 1'b1;
          produced_next    = prod_sat;
          if (lit_rem > 7'd1) begin
            lit_rem_next = lit_rem - 7'd1;
          end else begin
            lit_rem_next = '0;
            phase_next   = PH_CMD;
          end
        end
        default: begin
          phase_next = PH_SRC;
        end
      endcase
    end

    // Close the delta on its final byte
    if (stage_end && !done_early && !err_latched_next) begin
      end_has = 1'b1;
      if (phase_next == PH_CMD) begin
        if (PROD_CMP_W'(produced_next) == PROD_CMP_W'(target_len_next)) begin
          end_res = pdid_pkg::mk_status(pdid_pkg::KIND_OK, pdid_pkg::ERR_NONE);
        end else begin
          end_res = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR, pdid_pkg::ERR_FINAL_SIZE);
        end
      end else begin
        end_res = pdid_pkg::mk_status(pdid_pkg::KIND_ERROR, pdid_pkg::ERR_TRUNCATED);
      end
    end

    // Every delta end returns to the source header
    if (stage_end && !err_latched) begin
      phase_next       = PH_SRC;
      len_acc_next     = '0;
      vshift_next      = '0;
      target_len_next  = '0;
      op_flags_next    = '0;
      off_acc_next     = '0;
      clen_acc_next    = '0;
      lit_rem_next     = '0;
      produced_next    = '0;
      err_latched_next = 1'b0;
    end else if (err_latched && stage_end) begin
      len_acc_next    = '0;
      vshift_next     = '0;
      target_len_next = '0;
      op_flags_next   = '0;
      off_acc_next    = '0;
      clen_acc_next   = '0;
      lit_rem_next    = '0;
      produced_next   = '0;
    end
  end

  // Order the results of one byte
  assign res0    = main_has ? main_res : end_res;
  assign res1    = end_res;
  assign res_cnt = 2'(main_has) + 2'(end_has);

  // Decoder state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size   <= '0;
      phase       <= PH_SRC;
      len_acc     <= '0;
      vshift      <= '0;
      target_len  <= '0;
      op_flags    <= '0;
      off_acc     <= '0;
      clen_acc    <= '0;
      lit_rem     <= '0;
      produced    <= '0;
      err_latched <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_size <= cfg_wr_data;
      end
      if (fire) begin
        phase       <= phase_next;
        len_acc     <= len_acc_next;
        vshift      <= vshift_next;
        target_len  <= target_len_next;
        op_flags    <= op_flags_next;
        off_acc     <= off_acc_next;
        clen_acc    <= clen_acc_next;
        lit_rem     <= lit_rem_next;
        produced    <= produced_next;
        err_latched <= err_latched_next;
      end
    end
  end

  // Result queue: write up to two entries, read one
  assign q_pop = (q_cnt != '0) && result.ready;

  always_ff @(posedge clk) begin
    if (fire && (res_cnt != 2'd0)) begin
      q_mem[q_wr] <= res0;
    end
    if (fire && (res_cnt == 2'd2)) begin
      q_mem[q_wr + Q_PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (fire) begin
        q_wr <= q_wr + Q_PTR_W'(res_cnt);
      end
      if (q_pop) begin
        q_rd <= q_rd + Q_PTR_W'(1);
      end
      q_cnt <= q_cnt + (fire ? Q_CNT_W'(res_cnt) : '0) - Q_CNT_W'(q_pop);
    end
  end

  assign result.valid       = (q_cnt != '0);
  assign result.kind        = q_mem[q_rd].kind;
  assign result.literal     = q_mem[q_rd].literal;
  assign result.copy_offset = q_mem[q_rd].copy_offset;
  assign result.copy_length = q_mem[q_rd].copy_length;
  assign result.error_code  = q_mem[q_rd].error_code;
  assign result.is_last     = q_mem[q_rd].is_last;

endmodule

### sv/pdid_checker.sv
module pdid_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            valid,
  input logic                            ready,
  input logic [1:0]                      kind,
  input logic [pdid_pkg::BYTE_W-1:0]     literal,
  input logic [pdid_pkg::SIZE_W-1:0]     copy_offset,
  input logic [pdid_pkg::COPY_LEN_W-1:0] copy_length,
  input logic [2:0]                      error_code,
  input logic                            is_last
);

  // Copy descriptor carries a usable length and never closes a delta
  a_copy_shape: assert property (@(posedge clk) disable iff (rst)
    (valid && kind == pdid_pkg::KIND_COPY) |->
      (copy_length != '0 && copy_length <= pdid_pkg::COPY_MAX &&
       error_code == pdid_pkg::ERR_NONE && !is_last && literal == '0))
    else $error("malformed copy descriptor");

  // Error status closes the delta with a known code
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (valid && kind == pdid_pkg::KIND_ERROR) |->
      (is_last && error_code != pdid_pkg::ERR_NONE && error_code != 3'd7 &&
       copy_length == '0 && copy_offset == '0))
    else $error("malformed error status");

  // Literals and the good status carry no error code; only statuses close a delta
  a_plain_shape: assert property (@(posedge clk) disable iff (rst)
    (valid && (kind == pdid_pkg::KIND_LITERAL || kind == pdid_pkg::KIND_OK)) |->
      (error_code == pdid_pkg::ERR_NONE && copy_length == '0 &&
       is_last == (kind == pdid_pkg::KIND_OK)))
    else $error("malformed literal or status");

  // A stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=>
      (valid && $stable(kind) && $stable(literal) && $stable(copy_offset) &&
       $stable(copy_length) && $stable(error_code) && $stable(is_last)))
    else $error("result changed while stalled");

endmodule

bind pack_delta_instruction_decoder pdid_checker u_pdid_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .kind        (result.kind),
  .literal     (result.literal),
  .copy_offset (result.copy_offset),
  .copy_length (result.copy_length),
  .error_code  (result.error_code),
  .is_last     (result.is_last)
);
